/* src/framed_packet_xor_parser_core_macros.svh */
// Assertion macros for the framed packet parser core.
// Clocked on clock, disabled during reset; included by modules that check.
`ifndef FRAMED_PACKET_XOR_PARSER_CORE_MACROS_SVH
`define FRAMED_PACKET_XOR_PARSER_CORE_MACROS_SVH

// Same-cycle implication.
`define FPXP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FPXP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/fpxp_pkg.sv */
// Shared constants for the framed packet parser core.
// No dependencies.
`default_nettype none

package fpxp_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned PHASE_W  = 3;
   localparam int unsigned HEADER_W = 32;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [PHASE_W-1:0] phase_type;

   localparam kind_type KIND_DATA = 2'd0;
   localparam kind_type KIND_GOOD = 2'd1;
   localparam kind_type KIND_CSUM = 2'd2;
   localparam kind_type KIND_LEN  = 2'd3;

   localparam phase_type PH_HDR0 = 3'd0;
   localparam phase_type PH_HDR1 = 3'd1;
   localparam phase_type PH_HDR2 = 3'd2;
   localparam phase_type PH_HDR3 = 3'd3;
   localparam phase_type PH_LEN  = 3'd4;
   localparam phase_type PH_TOK  = 3'd5;
   localparam phase_type PH_CMD  = 3'd6;
   localparam phase_type PH_BODY = 3'd7;

   localparam logic CSR_HEADER = 1'b0;
   localparam logic CSR_TOKEN  = 1'b1;

   localparam logic [HEADER_W-1:0] HEADER_RESET = 32'h554E_4552;
   localparam byte_type            TOKEN_RESET  = 8'h3A;

endpackage

`default_nettype wire

/* src/framed_packet_xor_parser_core.sv */
// Framed packet parser with XOR checksum: header hunt, length/token check, payload stream.
// Depends on fpxp_pkg and framed_packet_xor_parser_core_macros.svh.
//
// Takes one received byte per beat and returns at most one result beat per byte.
// A byte is accepted every clock while the result register is empty or being
// drained; its result appears in the result register in the next cycle.
// Throughput is one byte per clock, set by the single result register that parts
// the two sides. Payload bytes go out with kind 0 and tlast low; each frame that passes the token
// check ends with one status beat (good, checksum error, length error) with tlast high, and the
// consumer drops the payload unless that status is good. The user must write configuration
// through the csr port only while the block is idle; the block itself does not enforce it.
`default_nettype none
`include "framed_packet_xor_parser_core_macros.svh"

module framed_packet_xor_parser_core
   import fpxp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] command, [15:8] payload_byte, [23:16] byte_index
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);

   logic [HEADER_W-1:0] header_ff;
   byte_type            token_ff;

   phase_type phase_ff, phase_in;
   byte_type  length_ff, length_in;
   byte_type  xor_ff, xor_in;
   byte_type  command_ff, command_in;
   byte_type  seen_ff, seen_in;

   logic      rsp_valid_ff, rsp_valid_in;
   kind_type  rsp_kind_ff;
   byte_type  rsp_command_ff, rsp_payload_ff, rsp_index_ff;
   logic      rsp_last_ff;

   logic      req_accept;
   logic      has_result;
   kind_type  res_kind;
   byte_type  res_command, res_payload, res_index;
   logic      res_last;
   logic      hunt;
   byte_type  hdr_byte;
   logic      body_data;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      unique case (phase_ff[1:0])
         2'd0:    hdr_byte = header_ff[31:24];
         2'd1:    hdr_byte = header_ff[23:16];
         2'd2:    hdr_byte = header_ff[15:8];
         2'd3:    hdr_byte = header_ff[7:0];
         default: hdr_byte = header_ff[31:24];
      endcase
   end

   assign body_data = ({1'b0, seen_ff} + 9'd2) < {1'b0, length_ff};

   always_comb begin
      phase_in    = phase_ff;
      length_in   = length_ff;
      xor_in      = xor_ff;
      command_in  = command_ff;
      seen_in     = seen_ff;
      has_result  = 1'b0;
      res_kind    = KIND_DATA;
      res_command = '0;
      res_payload = '0;
      res_index   = '0;
      res_last    = 1'b0;
      hunt        = 1'b0;
      if (req_accept) begin
         unique case (phase_ff) inside
            PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
               if (req_tdata == hdr_byte) begin
                  xor_in   = (phase_ff == PH_HDR0) ? req_tdata : (xor_ff ^ req_tdata);
                  phase_in = phase_ff + 3'd1;
               end else begin
                  hunt = 1'b1;
               end
            end
            PH_LEN: begin
               length_in = req_tdata;
               xor_in    = xor_ff ^ req_tdata;
               phase_in  = PH_TOK;
            end
            PH_TOK: begin
               if (req_tdata != token_ff) begin
                  hunt = 1'b1;
               end else if (length_ff[7:1] == 7'd0) begin
                  has_result = 1'b1;
                  res_kind   = KIND_LEN;
                  res_last   = 1'b1;
                  hunt       = 1'b1;
               end else begin
                  xor_in   = xor_ff ^ req_tdata;
                  phase_in = PH_CMD;
               end
            end
            PH_CMD: begin
               command_in = req_tdata;
               xor_in     = xor_ff ^ req_tdata;
               seen_in    = '0;
               phase_in   = PH_BODY;
            end
            default: begin
               has_result  = 1'b1;
               res_command = command_ff;
               if (body_data) begin
                  res_kind    = KIND_DATA;
                  res_payload = req_tdata;
                  res_index   = seen_ff;
                  xor_in      = xor_ff ^ req_tdata;
                  seen_in     = seen_ff + 8'd1;
               end else begin
                  res_kind = (xor_ff == req_tdata) ? KIND_GOOD : KIND_CSUM;
                  res_last = 1'b1;
                  hunt     = 1'b1;
               end
            end
         endcase
         if (hunt) begin
            phase_in   = PH_HDR0;
            length_in  = '0;
            xor_in     = '0;
            command_in = '0;
            seen_in    = '0;
         end
      end
   end

   assign rsp_valid_in = req_accept ? has_result : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         token_ff  <= TOKEN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEADER: header_ff <= csr_data;
            CSR_TOKEN:  token_ff  <= csr_data[7:0];
            default:    header_ff <= header_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         length_ff    <= '0;
         xor_ff       <= '0;
         command_ff   <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         length_ff    <= length_in;
         xor_ff       <= xor_in;
         command_ff   <= command_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && has_result) begin
         rsp_kind_ff    <= res_kind;
         rsp_command_ff <= res_command;
         rsp_payload_ff <= res_payload;
         rsp_index_ff   <= res_index;
         rsp_last_ff    <= res_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_index_ff, rsp_payload_ff, rsp_command_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `FPXP_ASSERT_NOW(a_stall_blocks_input, rsp_valid_ff && !rsp_tready, !req_tready,
      "input accepted while result stalled")
   `FPXP_ASSERT_NOW(a_last_matches_kind, rsp_valid_ff,
      rsp_last_ff == (rsp_kind_ff != KIND_DATA), "tlast disagrees with kind")
   `FPXP_ASSERT_NEXT(a_status_rehunts, req_accept && has_result && res_last,
      phase_ff == PH_HDR0 && xor_ff == 8'd0, "no return to hunting after status")
   `FPXP_ASSERT_NOW(a_body_count_bound, phase_ff == PH_BODY,
      ({1'b0, seen_ff} + 9'd2) <= {1'b0, length_ff}, "payload count past frame length")

endmodule

`default_nettype wire
